[hw/rtl/mmc_pkg.sv]
package mmc_pkg;

  localparam int SW     = 16;          // sample width
  localparam int AXES   = 3;
  localparam int AX_W   = 2;
  localparam int DIFF_W = SW + 1;      // sample minus offset
  localparam int D_W    = SW - 1;      // half-span
  localparam int SUM_W  = SW + 1;      // sum of three half-spans
  localparam int DIV_W  = SW + 1;      // 3 * half-span
  localparam int PROD_W = SW + SUM_W;  // |diff| * sum
  localparam int CNT_W  = $clog2(SW);
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int EXT_N  = 4;

  localparam int AX_X = 0;
  localparam int AX_Y = 1;
  localparam int AX_Z = 2;

  localparam int EXT_XLO = 0;
  localparam int EXT_XHI = 1;
  localparam int EXT_YLO = 2;
  localparam int EXT_YHI = 3;

  localparam logic [SW-1:0] SMAX = {1'b0, {(SW-1){1'b1}}};
  localparam logic [SW-1:0] SMIN = {1'b1, {(SW-1){1'b0}}};

  typedef struct packed {
    logic [AXES-1:0][DIFF_W-1:0] diff;
    logic [AXES-1:0][D_W-1:0]    span;
    logic [SUM_W-1:0]            sum;
    logic [EXT_N-1:0][SW-1:0]    ext;
  } job_t;

  typedef struct packed {
    logic full;
    logic avail;
  } q_stat_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_CHK,
    ST_DIV,
    ST_RES,
    ST_FIN
  } back_state_e;

endpackage

[hw/rtl/mmc_front.sv]
module mmc_front (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [mmc_pkg::SW-1:0]   sample_x_i,
  input  logic [mmc_pkg::SW-1:0]   sample_y_i,
  input  logic [mmc_pkg::SW-1:0]   sample_z_i,
  input  mmc_pkg::q_stat_t         q_stat_i,
  output logic                     push_o,
  output mmc_pkg::job_t            job_o
);

  logic                                          seeded_q;
  logic                                          s1_valid_q;
  logic [mmc_pkg::AXES-1:0][mmc_pkg::SW-1:0]     smp_in;
  logic [mmc_pkg::AXES-1:0][mmc_pkg::SW-1:0]     smp_q;
  logic [mmc_pkg::AXES-1:0][mmc_pkg::SW-1:0]     lo_q, lo_d, hi_q, hi_d;
  logic                                          accept;

  logic signed [mmc_pkg::SW:0] lo_ext  [mmc_pkg::AXES];
  logic signed [mmc_pkg::SW:0] hi_ext  [mmc_pkg::AXES];
  logic signed [mmc_pkg::SW:0] smp_ext [mmc_pkg::AXES];
  logic signed [mmc_pkg::SW:0] hl_sum  [mmc_pkg::AXES];
  logic signed [mmc_pkg::SW:0] hl_rnd  [mmc_pkg::AXES];
  logic signed [mmc_pkg::SW:0] hl_dif  [mmc_pkg::AXES];
  logic signed [mmc_pkg::SW:0] off     [mmc_pkg::AXES];

  assign smp_in[mmc_pkg::AX_X] = sample_x_i;
  assign smp_in[mmc_pkg::AX_Y] = sample_y_i;
  assign smp_in[mmc_pkg::AX_Z] = sample_z_i;

  assign push_o     = s1_valid_q && !q_stat_i.full;
  assign in_stall_o = s1_valid_q && !push_o;
  assign accept     = in_valid_i && !in_stall_o;

  // first beat after reset seeds both bounds
  always_comb begin
    for (int a = 0; a < mmc_pkg::AXES; a++) begin
      if (!seeded_q) begin
        lo_d[a] = smp_in[a];
        hi_d[a] = smp_in[a];
      end else begin
        lo_d[a] = ($signed(smp_in[a]) < $signed(lo_q[a])) ? smp_in[a] : lo_q[a];
        hi_d[a] = ($signed(smp_in[a]) > $signed(hi_q[a])) ? smp_in[a] : hi_q[a];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seeded_q   <= 1'b0;
      s1_valid_q <= 1'b0;
      lo_q       <= '0;
      hi_q       <= '0;
    end else begin
      if (accept) begin
        seeded_q   <= 1'b1;
        s1_valid_q <= 1'b1;
        lo_q       <= lo_d;
        hi_q       <= hi_d;
      end else if (push_o) begin
        s1_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      smp_q <= smp_in;
    end
  end

  // offset and half-span, both truncated toward zero
  always_comb begin
    for (int a = 0; a < mmc_pkg::AXES; a++) begin
      lo_ext[a]  = $signed({lo_q[a][mmc_pkg::SW-1], lo_q[a]});
      hi_ext[a]  = $signed({hi_q[a][mmc_pkg::SW-1], hi_q[a]});
      smp_ext[a] = $signed({smp_q[a][mmc_pkg::SW-1], smp_q[a]});
      hl_sum[a]  = hi_ext[a] + lo_ext[a];
      hl_rnd[a]  = hl_sum[a] + $signed({{mmc_pkg::SW{1'b0}}, hl_sum[a][mmc_pkg::SW]});
      off[a]     = hl_rnd[a] >>> 1;
      hl_dif[a]  = hi_ext[a] - lo_ext[a];
      job_o.diff[a] = smp_ext[a] - off[a];
      job_o.span[a] = hl_dif[a][mmc_pkg::SW-1:1];
    end
    job_o.sum = mmc_pkg::SUM_W'(job_o.span[mmc_pkg::AX_X])
              + mmc_pkg::SUM_W'(job_o.span[mmc_pkg::AX_Y])
              + mmc_pkg::SUM_W'(job_o.span[mmc_pkg::AX_Z]);
    job_o.ext[mmc_pkg::EXT_XLO] = lo_q[mmc_pkg::AX_X];
    job_o.ext[mmc_pkg::EXT_XHI] = hi_q[mmc_pkg::AX_X];
    job_o.ext[mmc_pkg::EXT_YLO] = lo_q[mmc_pkg::AX_Y];
    job_o.ext[mmc_pkg::EXT_YHI] = hi_q[mmc_pkg::AX_Y];
  end

endmodule

[hw/rtl/mmc_queue.sv]
module mmc_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  mmc_pkg::job_t    job_i,
  input  logic             pop_i,
  output mmc_pkg::job_t    job_o,
  output mmc_pkg::q_stat_t stat_o
);

  mmc_pkg::job_t                q_mem [mmc_pkg::QDEPTH];
  logic [mmc_pkg::QPTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [mmc_pkg::QPTR_W:0]     cnt_q;

  assign stat_o.full  = (cnt_q == (mmc_pkg::QPTR_W+1)'(mmc_pkg::QDEPTH));
  assign stat_o.avail = (cnt_q != '0);
  assign job_o        = q_mem[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      q_mem[wr_ptr_q] <= job_i;
    end
  end

endmodule

[hw/rtl/mmc_back.sv]
module mmc_back (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  mmc_pkg::q_stat_t       q_stat_i,
  input  mmc_pkg::job_t          job_i,
  output logic                   pop_o,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [mmc_pkg::SW-1:0] cal_x_o,
  output logic [mmc_pkg::SW-1:0] cal_y_o,
  output logic [mmc_pkg::SW-1:0] cal_z_o,
  output logic                   span_zero_o,
  output logic                   saturated_o,
  output logic [mmc_pkg::SW-1:0] x_lowest_o,
  output logic [mmc_pkg::SW-1:0] x_highest_o,
  output logic [mmc_pkg::SW-1:0] y_lowest_o,
  output logic [mmc_pkg::SW-1:0] y_highest_o
);

  mmc_pkg::back_state_e state_q, state_d;

  mmc_pkg::job_t                              job_q;
  logic [mmc_pkg::AX_W-1:0]                   ax_q;
  logic [mmc_pkg::CNT_W-1:0]                  cnt_q;
  logic [mmc_pkg::PROD_W-1:0]                 prod_q;
  logic [mmc_pkg::DIV_W-1:0]                  div_q;
  logic [mmc_pkg::DIV_W-1:0]                  rem_q;
  logic [mmc_pkg::SW-1:0]                     quo_q;
  logic                                       neg_q, spz_q;
  logic                                       zero_acc_q, sat_acc_q;
  logic [mmc_pkg::AXES-1:0][mmc_pkg::SW-1:0]  res_q;
  logic                                       out_valid_q;

  logic                                       ld_mul, ld_chk, step, ld_res, ld_out;
  logic                                       last_ax, ovf, ax_done;
  logic [mmc_pkg::DIFF_W-1:0]                 cur_diff, diff_neg;
  logic [mmc_pkg::D_W-1:0]                    cur_span;
  logic [mmc_pkg::SW-1:0]                     mag;
  logic [mmc_pkg::PROD_W-1:0]                 mul;
  logic [mmc_pkg::DIV_W-1:0]                  div3;
  logic [mmc_pkg::DIV_W:0]                    trial_in, trial;
  logic [mmc_pkg::SW-1:0]                     ax_res, quo_neg;
  logic                                       ax_sat;

  assign cur_diff = job_q.diff[ax_q];
  assign cur_span = job_q.span[ax_q];
  assign diff_neg = -cur_diff;
  assign mag      = cur_diff[mmc_pkg::DIFF_W-1] ? diff_neg[mmc_pkg::SW-1:0]
                                                : cur_diff[mmc_pkg::SW-1:0];
  assign mul      = mag * job_q.sum;
  assign div3     = mmc_pkg::DIV_W'(cur_span) + (mmc_pkg::DIV_W'(cur_span) << 1);
  assign last_ax  = (ax_q == mmc_pkg::AX_W'(mmc_pkg::AXES - 1));
  // quotient would need more than SW bits: clipped either way
  assign ovf      = (prod_q >= {div_q, {mmc_pkg::SW{1'b0}}});
  assign trial_in = {rem_q, quo_q[mmc_pkg::SW-1]};
  assign trial    = trial_in - {1'b0, div_q};
  assign quo_neg  = -quo_q;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      mmc_pkg::ST_IDLE: if (q_stat_i.avail) state_d = mmc_pkg::ST_MUL;
      mmc_pkg::ST_MUL:  state_d = mmc_pkg::ST_CHK;
      mmc_pkg::ST_CHK: begin
        if (spz_q || ovf) begin
          state_d = last_ax ? mmc_pkg::ST_FIN : mmc_pkg::ST_MUL;
        end else begin
          state_d = mmc_pkg::ST_DIV;
        end
      end
      mmc_pkg::ST_DIV: begin
        if (cnt_q == mmc_pkg::CNT_W'(mmc_pkg::SW - 1)) state_d = mmc_pkg::ST_RES;
      end
      mmc_pkg::ST_RES: state_d = last_ax ? mmc_pkg::ST_FIN : mmc_pkg::ST_MUL;
      mmc_pkg::ST_FIN: if (!out_valid_q || !out_stall_i) state_d = mmc_pkg::ST_IDLE;
      default: state_d = mmc_pkg::ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    pop_o   = 1'b0;
    ld_mul  = 1'b0;
    ld_chk  = 1'b0;
    step    = 1'b0;
    ld_res  = 1'b0;
    ld_out  = 1'b0;
    ax_done = 1'b0;
    unique case (state_q)
      mmc_pkg::ST_IDLE: pop_o = q_stat_i.avail;
      mmc_pkg::ST_MUL:  ld_mul = 1'b1;
      mmc_pkg::ST_CHK: begin
        ld_chk  = 1'b1;
        ax_done = spz_q || ovf;
      end
      mmc_pkg::ST_DIV:  step = 1'b1;
      mmc_pkg::ST_RES: begin
        ld_res  = 1'b1;
        ax_done = 1'b1;
      end
      mmc_pkg::ST_FIN:  ld_out = !out_valid_q || !out_stall_i;
      default: ;
    endcase
  end

  // per-axis result and clip
  always_comb begin
    ax_res = '0;
    ax_sat = 1'b0;
    if (spz_q) begin
      if ($signed(cur_diff) > $signed({1'b0, mmc_pkg::SMAX})) begin
        ax_res = mmc_pkg::SMAX;
        ax_sat = 1'b1;
      end else if ($signed(cur_diff) < $signed({1'b1, mmc_pkg::SMIN})) begin
        ax_res = mmc_pkg::SMIN;
        ax_sat = 1'b1;
      end else begin
        ax_res = cur_diff[mmc_pkg::SW-1:0];
      end
    end else if (!ld_res) begin
      ax_res = neg_q ? mmc_pkg::SMIN : mmc_pkg::SMAX;
      ax_sat = 1'b1;
    end else if (neg_q) begin
      if (quo_q[mmc_pkg::SW-1] && |quo_q[mmc_pkg::SW-2:0]) begin
        ax_res = mmc_pkg::SMIN;
        ax_sat = 1'b1;
      end else begin
        ax_res = quo_neg;
      end
    end else begin
      if (quo_q[mmc_pkg::SW-1]) begin
        ax_res = mmc_pkg::SMAX;
        ax_sat = 1'b1;
      end else begin
        ax_res = quo_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mmc_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (ld_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      job_q      <= job_i;
      ax_q       <= '0;
      zero_acc_q <= 1'b0;
      sat_acc_q  <= 1'b0;
    end
    if (ld_mul) begin
      prod_q <= mul;
      div_q  <= div3;
      neg_q  <= cur_diff[mmc_pkg::DIFF_W-1];
      spz_q  <= (cur_span == '0);
    end
    if (ld_chk) begin
      // unless ovf, prod < div << SW, so the upper part is already below the divisor
      rem_q <= prod_q[mmc_pkg::PROD_W-1:mmc_pkg::SW];
      quo_q <= prod_q[mmc_pkg::SW-1:0];
      cnt_q <= '0;
    end
    if (step) begin
      cnt_q <= cnt_q + 1'b1;
      if (!trial[mmc_pkg::DIV_W]) begin
        rem_q <= trial[mmc_pkg::DIV_W-1:0];
        quo_q <= {quo_q[mmc_pkg::SW-2:0], 1'b1};
      end else begin
        rem_q <= trial_in[mmc_pkg::DIV_W-1:0];
        quo_q <= {quo_q[mmc_pkg::SW-2:0], 1'b0};
      end
    end
    if (ax_done) begin
      res_q[ax_q] <= ax_res;
      sat_acc_q   <= sat_acc_q | ax_sat;
      zero_acc_q  <= zero_acc_q | spz_q;
      if (!last_ax) begin
        ax_q <= ax_q + 1'b1;
      end
    end
    if (ld_out) begin
      cal_x_o     <= res_q[mmc_pkg::AX_X];
      cal_y_o     <= res_q[mmc_pkg::AX_Y];
      cal_z_o     <= res_q[mmc_pkg::AX_Z];
      span_zero_o <= zero_acc_q;
      saturated_o <= sat_acc_q;
      x_lowest_o  <= job_q.ext[mmc_pkg::EXT_XLO];
      x_highest_o <= job_q.ext[mmc_pkg::EXT_XHI];
      y_lowest_o  <= job_q.ext[mmc_pkg::EXT_YLO];
      y_highest_o <= job_q.ext[mmc_pkg::EXT_YHI];
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

[hw/rtl/magnetometer_minmax_calibrator_top.sv]
// Each accepted beat is registered in the front stage and queued; the back end pops
//   it and per axis runs multiply, check, divide and result steps; an axis with zero
//   half-span or an overflowing quotient skips the divide. A single shared restoring
//   divider (one quotient bit per cycle, 16 per axis, three axes) serves one job at a time.
// Reset: async active low; clears the seed flag, bounds, queue and valid flags.
module magnetometer_minmax_calibrator_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [mmc_pkg::SW-1:0] sample_x_i,
  input  logic signed [mmc_pkg::SW-1:0] sample_y_i,
  input  logic signed [mmc_pkg::SW-1:0] sample_z_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [mmc_pkg::SW-1:0] cal_x_o,
  output logic signed [mmc_pkg::SW-1:0] cal_y_o,
  output logic signed [mmc_pkg::SW-1:0] cal_z_o,
  output logic                          span_zero_o,
  output logic                          saturated_o,
  output logic signed [mmc_pkg::SW-1:0] x_lowest_o,
  output logic signed [mmc_pkg::SW-1:0] x_highest_o,
  output logic signed [mmc_pkg::SW-1:0] y_lowest_o,
  output logic signed [mmc_pkg::SW-1:0] y_highest_o
);

  mmc_pkg::job_t    front_job, back_job;
  mmc_pkg::q_stat_t q_stat;
  logic             push, pop;

  mmc_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sample_x_i (sample_x_i),
    .sample_y_i (sample_y_i),
    .sample_z_i (sample_z_i),
    .q_stat_i   (q_stat),
    .push_o     (push),
    .job_o      (front_job)
  );

  mmc_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .job_i  (front_job),
    .pop_i  (pop),
    .job_o  (back_job),
    .stat_o (q_stat)
  );

  mmc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_stat_i    (q_stat),
    .job_i       (back_job),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cal_x_o     (cal_x_o),
    .cal_y_o     (cal_y_o),
    .cal_z_o     (cal_z_o),
    .span_zero_o (span_zero_o),
    .saturated_o (saturated_o),
    .x_lowest_o  (x_lowest_o),
    .x_highest_o (x_highest_o),
    .y_lowest_o  (y_lowest_o),
    .y_highest_o (y_highest_o)
  );

endmodule

[hw/rtl/mmc_checker.sv]
module mmc_checker (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   in_valid_i,
  input logic                   in_stall_o,
  input logic [mmc_pkg::SW-1:0] sample_x_i,
  input logic [mmc_pkg::SW-1:0] sample_y_i,
  input logic [mmc_pkg::SW-1:0] sample_z_i,
  input logic                   out_valid_o,
  input logic                   out_stall_i,
  input logic [mmc_pkg::SW-1:0] cal_x_o,
  input logic [mmc_pkg::SW-1:0] cal_y_o,
  input logic [mmc_pkg::SW-1:0] cal_z_o,
  input logic                   span_zero_o,
  input logic                   saturated_o,
  input logic [mmc_pkg::SW-1:0] x_lowest_o,
  input logic [mmc_pkg::SW-1:0] x_highest_o,
  input logic [mmc_pkg::SW-1:0] y_lowest_o,
  input logic [mmc_pkg::SW-1:0] y_highest_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(cal_x_o) && $stable(cal_y_o)
      && $stable(cal_z_o) && $stable(span_zero_o) && $stable(saturated_o)
      && $stable(x_lowest_o) && $stable(y_highest_o))
    else $error("result beat changed while stalled");

  a_x_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $signed(x_lowest_o) <= $signed(x_highest_o))
    else $error("x bounds out of order");

  a_y_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $signed(y_lowest_o) <= $signed(y_highest_o))
    else $error("y bounds out of order");

  // collapsed x range means the sample sits on the offset exactly
  a_x_flat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (x_lowest_o == x_highest_o) |-> (cal_x_o == '0) && span_zero_o)
    else $error("flat x range gave nonzero result");

endmodule

bind magnetometer_minmax_calibrator_top mmc_checker u_mmc_checker (.*);
